// ===== rtl/kpsd_pkg.sv =====
// ----------------------------------------------------------------------------
// kpsd_pkg
// Shared types, constants and the multi-tap letter table for the keypad
// scanner with debounce and multi-tap letter selection.
// ----------------------------------------------------------------------------
package kpsd_pkg;

	localparam int unsigned TABLE_ROWS  = 4;
	localparam int unsigned TABLE_COLS  = 3;
	localparam int unsigned TABLE_WIDTH = 5;

	localparam int unsigned COL_IN_W   = 3;
	localparam int unsigned ROW_OUT_W  = 4;
	localparam int unsigned KEY_NUM_W  = 4;
	localparam int unsigned CHAR_W     = 8;
	localparam int unsigned COUNT_W    = 10;
	localparam int unsigned TAP_W      = 3;

	localparam logic [COUNT_W-1:0] COUNT_MAX      = '1;
	localparam logic [COUNT_W-1:0] DEBOUNCE_RESET = 10'd100;
	localparam logic [CHAR_W-1:0]  WRAP_MARK      = "-";

	typedef enum logic [3:0] {
		PH_SCAN    = 4'b0001,
		PH_PRESS   = 4'b0010,
		PH_HELD    = 4'b0100,
		PH_RELEASE = 4'b1000
	} kpsd_phase_t;

	typedef struct packed {
		logic [ROW_OUT_W-1:0] row_drive;
		logic                 key_valid;
		logic [KEY_NUM_W-1:0] key_number;
		logic [CHAR_W-1:0]    key_char;
	} kpsd_result_t;

	localparam logic [CHAR_W-1:0] LETTER_TABLE [TABLE_ROWS][TABLE_COLS][TABLE_WIDTH] = '{
		'{ '{"1", "-", "-", "-", "-"}, '{"A", "B", "C", "2", "-"}, '{"D", "E", "F", "3", "-"} },
		'{ '{"G", "H", "I", "4", "-"}, '{"J", "K", "L", "5", "-"}, '{"M", "N", "O", "6", "-"} },
		'{ '{"P", "Q", "R", "S", "7"}, '{"T", "U", "V", "8", "-"}, '{"W", "X", "Y", "Z", "9"} },
		'{ '{"*", "-", "-", "-", "-"}, '{"0", " ", "-", "-", "-"}, '{"#", "-", "-", "-", "-"} }
	};

endpackage

// ===== rtl/keypad_scan_debounce_multitap_core.sv =====
// ----------------------------------------------------------------------------
// keypad_scan_debounce_multitap_core
// Keypad scanner with debounce and multi-tap letters: one result per input transaction.
// Each input transaction is captured in the input register; the scan state
// update then goes into the result register. Throughput: one transaction per
// cycle while out_ready is high; a waiting result still lets the input register
// take one more. Reset clears valid and scan state, debounce_ticks = 100.
// ----------------------------------------------------------------------------
module keypad_scan_debounce_multitap_core #(
	parameter int unsigned ROWS            = 4,
	parameter int unsigned COLUMNS         = 3,
	parameter int unsigned LETTERS_PER_KEY = 5
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [kpsd_pkg::COUNT_W-1:0]     cfg_wr_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [kpsd_pkg::COL_IN_W-1:0]    column_lines,
	input  logic                             clear_tap,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [kpsd_pkg::ROW_OUT_W-1:0]   row_drive,
	output logic                             key_valid,
	output logic [kpsd_pkg::KEY_NUM_W-1:0]   key_number,
	output logic [kpsd_pkg::CHAR_W-1:0]      key_char
);
	import kpsd_pkg::*;

	logic [COUNT_W-1:0]  debounce_ticks_q;
	logic                valid_s1;
	logic [COL_IN_W-1:0] column_lines_s1;
	logic                clear_tap_s1;
	logic                advance;
	logic                out_valid_q;
	kpsd_result_t        result;
	kpsd_result_t        result_q;

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_ticks_q <= DEBOUNCE_RESET;
		end else if (cfg_wr_en) begin
			debounce_ticks_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			column_lines_s1 <= column_lines;
			clear_tap_s1    <= clear_tap;
		end
	end

	kpsd_scan_fsm #(
		.ROWS            (ROWS),
		.COLUMNS         (COLUMNS),
		.LETTERS_PER_KEY (LETTERS_PER_KEY)
	) u_scan_fsm (
		.clk            (clk),
		.arst_n         (arst_n),
		.advance        (advance),
		.column_lines   (column_lines_s1),
		.clear_tap      (clear_tap_s1),
		.debounce_ticks (debounce_ticks_q),
		.result         (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result;
		end
	end

	assign out_valid  = out_valid_q;
	assign row_drive  = result_q.row_drive;
	assign key_valid  = result_q.key_valid;
	assign key_number = result_q.key_number;
	assign key_char   = result_q.key_char;

endmodule

// ===== rtl/kpsd_scan_fsm.sv =====
// ----------------------------------------------------------------------------
// kpsd_scan_fsm
// Row scan, press/release debounce, key decode and multi-tap letter state.
// Updates once per advanced transaction and presents the post-update result.
// ----------------------------------------------------------------------------
module kpsd_scan_fsm #(
	parameter int unsigned ROWS            = 4,
	parameter int unsigned COLUMNS         = 3,
	parameter int unsigned LETTERS_PER_KEY = 5
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            advance,
	input  logic [kpsd_pkg::COL_IN_W-1:0]   column_lines,
	input  logic                            clear_tap,
	input  logic [kpsd_pkg::COUNT_W-1:0]    debounce_ticks,
	output kpsd_pkg::kpsd_result_t          result
);
	import kpsd_pkg::*;

	localparam int unsigned ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam logic [COL_IN_W-1:0] COL_MASK =
		(COLUMNS >= 3) ? 3'b111 : COL_IN_W'((1 << COLUMNS) - 1);

	kpsd_phase_t          phase_q, phase_d;
	logic [ROW_W-1:0]     row_q, row_d;
	logic [COUNT_W-1:0]   count_q, count_d;
	logic [TAP_W-1:0]     tap_q, tap_d;
	logic [KEY_NUM_W-1:0] key_num_q, key_num_d;
	logic [CHAR_W-1:0]    key_char_q, key_char_d;

	logic                 idle;
	logic [2:0]           row3;
	logic [1:0]           col;
	logic [TAP_W-1:0]     tap_eff;
	logic                 in_table;
	logic                 tap_ok;
	logic [CHAR_W-1:0]    letter;
	logic [CHAR_W-1:0]    dec_char;
	logic [TAP_W-1:0]     dec_tap;
	logic [7:0]           num_full;
	logic [3:0]           row_next;
	logic [COUNT_W-1:0]   count_inc;
	logic                 count_done;
	logic [2:0]           row3_d;

	assign idle       = ((column_lines & COL_MASK) == COL_MASK);
	assign row3       = 3'(row_q);
	assign col        = !column_lines[0] ? 2'd0 : (!column_lines[1] ? 2'd1 : 2'd2);
	assign tap_eff    = clear_tap ? '0 : tap_q;
	assign in_table   = (row3 < 3'(TABLE_ROWS));
	assign tap_ok     = ({1'b0, tap_eff} < 4'(LETTERS_PER_KEY))
		&& (tap_eff < TAP_W'(TABLE_WIDTH));
	assign count_inc  = (count_q == COUNT_MAX) ? count_q : count_q + 1'b1;
	assign count_done = (count_q >= debounce_ticks);
	assign num_full   = 8'(row3) * 8'(COLUMNS) + 8'(col) + 8'd1;
	assign row_next   = 4'(row3) + 4'd1;

	always_comb begin
		letter = WRAP_MARK;
		if (tap_ok) begin
			letter = LETTER_TABLE[row3[1:0]][col][tap_eff];
		end
		if (letter == WRAP_MARK) begin
			dec_char = LETTER_TABLE[row3[1:0]][col][0];
			dec_tap  = TAP_W'(1);
		end else begin
			dec_char = letter;
			dec_tap  = tap_eff + 1'b1;
		end
	end

	always_comb begin
		phase_d    = phase_q;
		row_d      = row_q;
		count_d    = count_q;
		tap_d      = tap_eff;
		key_num_d  = key_num_q;
		key_char_d = key_char_q;
		case (phase_q)
			PH_SCAN: begin
				if (idle) begin
					row_d = (row_next >= 4'(ROWS)) ? '0 : ROW_W'(row_next);
				end else begin
					count_d = '0;
					phase_d = PH_PRESS;
				end
			end
			PH_PRESS: begin
				if (!idle && count_done) begin
					key_num_d = num_full[KEY_NUM_W-1:0];
					if (in_table) begin
						key_char_d = dec_char;
						tap_d      = dec_tap;
					end else begin
						key_char_d = '0;
					end
					phase_d = PH_HELD;
				end else if (idle) begin
					row_d   = '0;
					phase_d = PH_SCAN;
				end else begin
					count_d = count_inc;
				end
			end
			PH_HELD: begin
				if (idle) begin
					count_d = '0;
					phase_d = PH_RELEASE;
				end
			end
			PH_RELEASE: begin
				if (idle && count_done) begin
					key_num_d  = '0;
					key_char_d = '0;
					row_d      = '0;
					phase_d    = PH_SCAN;
				end else if (!idle) begin
					phase_d = PH_HELD;
				end else begin
					count_d = count_inc;
				end
			end
			default: begin
				row_d   = '0;
				phase_d = PH_SCAN;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_SCAN;
			row_q      <= '0;
			count_q    <= '0;
			tap_q      <= '0;
			key_num_q  <= '0;
			key_char_q <= '0;
		end else if (advance) begin
			phase_q    <= phase_d;
			row_q      <= row_d;
			count_q    <= count_d;
			tap_q      <= tap_d;
			key_num_q  <= key_num_d;
			key_char_q <= key_char_d;
		end
	end

	assign row3_d = 3'(row_d);

	always_comb begin
		result.row_drive  = 4'hF;
		if (row3_d < 3'(ROW_OUT_W)) begin
			result.row_drive = ~(4'b0001 << row3_d[1:0]);
		end
		result.key_valid  = (phase_d == PH_HELD) || (phase_d == PH_RELEASE);
		result.key_number = result.key_valid ? key_num_d : '0;
		result.key_char   = result.key_valid ? key_char_d : '0;
	end

endmodule

// ===== rtl/kpsd_checker.sv =====
// ----------------------------------------------------------------------------
// kpsd_checker
// Port-level checks for the keypad scanner, bound to the top level.
// ----------------------------------------------------------------------------
module kpsd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [3:0] row_drive,
	input logic       key_valid,
	input logic [3:0] key_number,
	input logic [7:0] key_char
);

	a_idle_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !key_valid |-> key_number == 4'd0 && key_char == 8'd0)
		else $error("key fields nonzero without a held key");

	a_one_row_low: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $countones(~row_drive) <= 1)
		else $error("more than one row driven low");

	a_ready_when_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled while result register is empty");

	a_result_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
		else $error("result appeared without a transaction two cycles earlier");

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(row_drive)
			&& $stable(key_valid) && $stable(key_number) && $stable(key_char))
		else $error("stalled result changed");

endmodule

bind keypad_scan_debounce_multitap_core kpsd_checker u_kpsd_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.row_drive  (row_drive),
	.key_valid  (key_valid),
	.key_number (key_number),
	.key_char   (key_char)
);
